FILE: hw/rtl/dwc3_pkg.sv
// shared types, register indexes and output rounding for the 3x3 depthwise convolution
package dwc3_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_COEF_A       = 3'd2;
  localparam logic [2:0] REG_COEF_B       = 3'd3;
  localparam logic [2:0] REG_COEF_C       = 3'd4;
  localparam logic [2:0] REG_CLAMP_LOW    = 3'd5;
  localparam logic [2:0] REG_CLAMP_HIGH   = 3'd6;

  // one pixel or tap, a single tap product, a row partial sum, the full accumulator
  typedef logic signed [15:0] sample_t;
  typedef logic signed [31:0] prod_t;
  typedef logic signed [33:0] psum_t;
  typedef logic signed [35:0] acc_t;
  typedef logic [2:0] cfg_idx_t;

  // round half up from Q.22 (offset already added), saturate, then clamp low then high
  function automatic sample_t conv_finish(acc_t acc, sample_t lo, sample_t hi);
    logic signed [21:0] q;
    sample_t v;
    q = acc[35:14];
    if (q > 22'sd32767) begin
      v = 16'sh7fff;
    end else if (q < -22'sd32768) begin
      v = 16'sh8000;
    end else begin
      v = q[15:0];
    end
    if (v < lo) begin
      v = lo;
    end
    if (v > hi) begin
      v = hi;
    end
    return v;
  endfunction

endpackage

FILE: hw/rtl/depthwise_conv3x3_pad1_clamp.sv
// top level: 3x3 depthwise convolution, stride 1, zero padding of one, clamped Q7.8 output
// path: an accepted sample passes stage 1, stage 2 (products), stage 3 (row sums) and the output register
// throughput: one sample per cycle while the master side is ready; a last-column sample with two results holds the
//   output register for two transactions, so the input side stalls while both are held
// reset: rst (synchronous) clears row/column position, window, pipeline valids, output
//   pending flags and restores register defaults; the two line stores are not cleared
module depthwise_conv3x3_pad1_clamp #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic              clk,
  input  logic              rst,
  // sample stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // [15:0] sample
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,   // [15:0] value
  output logic              m_axis_tlast,   // run_last
  output logic [1:0]        m_axis_tuser,   // [0] row_end, [1] frame_end
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  dwc3_pkg::cfg_idx_t cfg_index,
  input  logic [63:0]       cfg_data
);
  import dwc3_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  // configuration registers, width and height kept in clamped form
  logic [CW-1:0]  width_m1;
  logic [RW-1:0]  height;
  logic [63:0]    coef_a;
  logic [63:0]    coef_b;
  logic [31:0]    coef_c;
  sample_t        clamp_low;
  sample_t        clamp_high;

  logic [10:0]    cfg_w;
  logic [12:0]    cfg_h;

  assign cfg_ready = 1'b1;
  assign cfg_w = cfg_data[10:0];
  assign cfg_h = cfg_data[12:0];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      width_m1   <= '0;
      height     <= RW'(1);
      coef_a     <= '0;
      coef_b     <= '0;
      coef_c     <= '0;
      clamp_low  <= 16'sh8000;
      clamp_high <= 16'sh7fff;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          if (cfg_w == 11'd0) begin
            width_m1 <= '0;
          end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
            width_m1 <= CW'(MAX_WIDTH - 1);
          end else begin
            width_m1 <= CW'(cfg_w - 11'd1);
          end
        end
        REG_FRAME_HEIGHT: begin
          if (cfg_h == 13'd0) begin
            height <= RW'(1);
          end else if (32'(cfg_h) > 32'(MAX_HEIGHT)) begin
            height <= RW'(MAX_HEIGHT);
          end else begin
            height <= RW'(cfg_h);
          end
        end
        REG_COEF_A:     coef_a     <= cfg_data;
        REG_COEF_B:     coef_b     <= cfg_data;
        REG_COEF_C:     coef_c     <= cfg_data[31:0];
        REG_CLAMP_LOW:  clamp_low  <= cfg_data[15:0];
        REG_CLAMP_HIGH: clamp_high <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // tap lanes, row-major from top-left
  sample_t taps [9];
  sample_t bias;
  assign taps[0] = coef_a[31:16];
  assign taps[1] = coef_a[47:32];
  assign taps[2] = coef_a[63:48];
  assign taps[3] = coef_b[15:0];
  assign taps[4] = coef_b[31:16];
  assign taps[5] = coef_b[47:32];
  assign taps[6] = coef_b[63:48];
  assign taps[7] = coef_c[15:0];
  assign taps[8] = coef_c[31:16];
  assign bias    = coef_a[15:0];

  // pipeline handshake between stages
  logic v1, v2, v3;
  logic ld1, ld2, ld3;
  logic slot_ready;
  logic accept;

  assign ld3 = !v3 || slot_ready;
  assign ld2 = !v2 || ld3;
  assign ld1 = !v1 || ld2;
  assign s_axis_tready = ld1;
  assign accept = s_axis_tvalid && ld1;

  // raster position, clamped against the current frame size
  logic [CW-1:0] col_index;
  logic [RW-1:0] row_index;
  logic [CW-1:0] c_eff;
  logic [RW-1:0] r_eff;
  logic          last_col;

  assign c_eff    = (col_index > width_m1) ? width_m1 : col_index;
  assign r_eff    = (row_index > height) ? height : row_index;
  assign last_col = (c_eff == width_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_index <= '0;
      row_index <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_index <= '0;
        row_index <= (r_eff >= height) ? '0 : r_eff + RW'(1);
      end else begin
        col_index <= c_eff + CW'(1);
      end
    end
  end

  // stage 1: sample and flags, line store read under way
  logic [CW-1:0] s1_c;
  sample_t       s1_col2;
  logic          s1_rge1, s1_rge2, s1_c0, s1_last, s1_fe;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ld1) begin
      v1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_c    <= c_eff;
      s1_col2 <= (r_eff < height) ? sample_t'(s_axis_tdata) : '0;
      s1_rge1 <= (r_eff != '0);
      s1_rge2 <= (r_eff > RW'(1));
      s1_c0   <= (c_eff == '0);
      s1_last <= last_col;
      s1_fe   <= (r_eff == height);
    end
  end

  // line stores with registered read and same-address forwarding from stage 1
  sample_t line_one [MAX_WIDTH];
  sample_t line_two [MAX_WIDTH];
  sample_t l1_q, l2_q;
  sample_t byp1, byp2;
  logic    byp_hit;
  sample_t lo1_raw, lo2_raw;
  logic    retire1;

  assign retire1 = v1 && ld2;
  assign lo1_raw = byp_hit ? byp1 : l1_q;
  assign lo2_raw = byp_hit ? byp2 : l2_q;

  always_ff @(posedge clk) begin
    if (retire1) begin
      line_one[s1_c] <= s1_col2;
      line_two[s1_c] <= lo1_raw;
    end
    if (ld1) begin
      l1_q <= line_one[c_eff];
      l2_q <= line_two[c_eff];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else if (ld1) begin
      byp_hit <= v1 && (s1_c == c_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      byp1 <= s1_col2;
      byp2 <= lo1_raw;
    end
  end

  // new window column: rows r-2, r-1, r
  sample_t col [3];
  assign col[0] = s1_rge2 ? lo2_raw : '0;
  assign col[1] = s1_rge1 ? lo1_raw : '0;
  assign col[2] = s1_col2;

  // window of the two previous columns
  sample_t win_left [3];
  sample_t win_mid  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        win_left[i] <= '0;
        win_mid[i]  <= '0;
      end
    end else if (retire1) begin
      for (int i = 0; i < 3; i++) begin
        win_left[i] <= s1_c0 ? sample_t'(0) : win_mid[i];
        win_mid[i]  <= col[i];
      end
    end
  end

  // tap products: a is the centered output, b the right-edge output of a last column
  prod_t pa_next [9];
  prod_t pb_next [6];
  logic  ra1, rb1;

  assign ra1 = !s1_c0 && s1_rge1;
  assign rb1 = s1_last && s1_rge1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa_next[3*i]     = taps[3*i] * win_left[i];
      pa_next[3*i + 1] = taps[3*i + 1] * win_mid[i];
      pa_next[3*i + 2] = taps[3*i + 2] * col[i];
      pb_next[2*i]     = taps[3*i] * (s1_c0 ? sample_t'(0) : win_mid[i]);
      pb_next[2*i + 1] = taps[3*i + 1] * col[i];
    end
  end

  // stage 2: registered products
  prod_t pa [9];
  prod_t pb [6];
  logic  ra2, rb2, fe2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ld2) begin
      v2 <= v1 && (ra1 || rb1);
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      pa  <= pa_next;
      pb  <= pb_next;
      ra2 <= ra1;
      rb2 <= rb1;
      fe2 <= s1_fe;
    end
  end

  // stage 3: row partial sums
  psum_t sa [3];
  psum_t sb [3];
  logic  ra3, rb3, fe3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ld3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      for (int i = 0; i < 3; i++) begin
        sa[i] <= psum_t'(pa[3*i]) + psum_t'(pa[3*i + 1]) + psum_t'(pa[3*i + 2]);
        sb[i] <= psum_t'(pb[2*i]) + psum_t'(pb[2*i + 1]);
      end
      ra3 <= ra2;
      rb3 <= rb2;
      fe3 <= fe2;
    end
  end

  // bias in Q.22 with the rounding half folded in, then total and finish
  acc_t    bias_term;
  acc_t    acc_a, acc_b;
  sample_t val_a_next, val_b_next;

  assign bias_term  = {{6{bias[15]}}, bias, 14'h2000};
  assign acc_a      = bias_term + acc_t'(sa[0]) + acc_t'(sa[1]) + acc_t'(sa[2]);
  assign acc_b      = bias_term + acc_t'(sb[0]) + acc_t'(sb[1]) + acc_t'(sb[2]);
  assign val_a_next = conv_finish(acc_a, clamp_low, clamp_high);
  assign val_b_next = conv_finish(acc_b, clamp_low, clamp_high);

  // output register holding up to two results of one sample
  logic    pend_a, pend_b;
  sample_t val_a, val_b;
  logic    tl_a, fe_b;
  logic    out_hs;
  logic    load_slot;

  assign out_hs     = m_axis_tvalid && m_axis_tready;
  assign slot_ready = !(pend_a || pend_b) || (out_hs && !(pend_a && pend_b));
  assign load_slot  = v3 && slot_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_a <= 1'b0;
      pend_b <= 1'b0;
    end else if (load_slot) begin
      pend_a <= ra3;
      pend_b <= rb3;
    end else if (out_hs) begin
      if (pend_a) begin
        pend_a <= 1'b0;
      end else begin
        pend_b <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_slot) begin
      val_a <= val_a_next;
      val_b <= val_b_next;
      tl_a  <= !rb3;
      fe_b  <= fe3;
    end
  end

  // result transaction
  assign m_axis_tvalid = pend_a || pend_b;
  assign m_axis_tdata  = pend_a ? val_a : val_b;
  assign m_axis_tlast  = pend_a ? tl_a : 1'b1;
  assign m_axis_tuser  = pend_a ? 2'b00 : {fe_b, 1'b1};

endmodule

FILE: bench/depthwise_conv3x3_pad1_clamp_tb.sv
// self-checking bench for the padded 3x3 depthwise convolution with clamped output
module depthwise_conv3x3_pad1_clamp_tb;
  import dwc3_pkg::*;

  localparam int unsigned MAX_W = 1024;
  localparam int unsigned MAX_H = 4096;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_SAMPLES = 1100;
  localparam int unsigned CYCLE_LIMIT = 600000;

  // three window rows of one column, top row in lane 0
  typedef logic [2:0][15:0] column_t;

  typedef struct packed {
    sample_t value;
    logic    run_last;
    logic    row_end;
    logic    frame_end;
  } conv_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = 16'h0000;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = REG_FRAME_WIDTH;
  logic [63:0] cfg_data = 64'h0;

  // stimulus and expectation stores
  sample_t      samples_to_send[$];
  conv_result_t conv_pixels_due[$];

  int unsigned send_idle_pct = 29;
  int unsigned recv_idle_pct = 77;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned samples_taken = 0;
  int unsigned samples_queued = 0;
  int unsigned pixels_checked = 0;
  int unsigned frames_closed = 0;

  // coefficient set last written, kept for the mid-plane resize
  logic [63:0] last_coef_a, last_coef_b;
  logic [31:0] last_coef_c;
  sample_t     last_lo, last_hi;

  // predictor copy of the registers
  logic [10:0] cur_width;
  logic [12:0] cur_height;
  logic [63:0] cur_coef_a, cur_coef_b;
  logic [31:0] cur_coef_c;
  sample_t     cur_lo, cur_hi;

  // predictor copy of position, line stores and window
  int unsigned at_row, at_col;
  sample_t     line_prev2 [MAX_W];
  sample_t     line_prev1 [MAX_W];
  column_t     win_left, win_mid;

  depthwise_conv3x3_pad1_clamp u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // bias plus nine taps, round half up to Q7.8, saturate, clamp low then high
  function automatic sample_t conv_pixel(column_t lcol, column_t mcol, column_t rcol);
    logic [8:0][15:0] tap;
    longint acc;
    longint q;
    sample_t v;
    int i;
    tap = {cur_coef_c, cur_coef_b, cur_coef_a[63:16]};
    acc = longint'($signed(cur_coef_a[15:0])) * 16384;
    for (i = 0; i < 3; i++) begin
      acc += longint'($signed(tap[3*i]))     * longint'($signed(lcol[i]));
      acc += longint'($signed(tap[3*i + 1])) * longint'($signed(mcol[i]));
      acc += longint'($signed(tap[3*i + 2])) * longint'($signed(rcol[i]));
    end
    q = (acc + 8192) >>> 14;
    if (q > 32767) begin
      v = 16'sh7fff;
    end else if (q < -32768) begin
      v = 16'sh8000;
    end else begin
      v = q[15:0];
    end
    if (v < cur_lo) begin
      v = cur_lo;
    end
    if (v > cur_hi) begin
      v = cur_hi;
    end
    return v;
  endfunction

  // advance the window by one accepted sample and queue the pixels it completes
  task automatic track_sample(sample_t s);
    int unsigned w, h, r, c;
    column_t newcol;
    conv_result_t res;
    logic last_col;
    w = cur_width;
    h = cur_height;
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    if (h == 0) h = 1;
    if (h > MAX_H) h = MAX_H;
    if (at_col >= w) at_col = w - 1;
    if (at_row > h) at_row = h;
    r = at_row;
    c = at_col;
    last_col = (c == w - 1);
    // rows r-2, r-1, r of this column; outside the plane reads zero
    newcol[0] = (r >= 2) ? line_prev2[c] : 16'h0000;
    newcol[1] = (r >= 1) ? line_prev1[c] : 16'h0000;
    newcol[2] = (r < h) ? s : 16'sh0000;
    line_prev2[c] = line_prev1[c];
    line_prev1[c] = newcol[2];
    if (c == 0) begin
      win_left = '0;
      win_mid = newcol;
    end else begin
      if (r >= 1) begin
        res.value = conv_pixel(win_left, win_mid, newcol);
        res.run_last = !last_col;
        res.row_end = 1'b0;
        res.frame_end = 1'b0;
        conv_pixels_due.push_back(res);
      end
      win_left = win_mid;
      win_mid = newcol;
    end
    // right edge pixel of the row above, right neighbor is padding
    if (last_col && r >= 1) begin
      res.value = conv_pixel(win_left, win_mid, '0);
      res.run_last = 1'b1;
      res.row_end = 1'b1;
      res.frame_end = (r == h);
      conv_pixels_due.push_back(res);
    end
    if (last_col) begin
      at_col = 0;
      at_row = (r >= h) ? 0 : r + 1;
    end else begin
      at_col = c + 1;
    end
  endtask

  task automatic report_mismatch(string what, int got_v, int want_v);
    $display("mismatch at output %0d, %s: got %0d, expected %0d",
             pixels_checked, what, got_v, want_v);
    mismatch_count++;
  endtask

  // sample driver: keeps tdata stable until the transaction completes
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (samples_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tdata <= samples_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result side backpressure
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // monitor: register writes, accepted samples, checked results
  always @(posedge clk) begin : monitor
    conv_result_t want;
    if (rst) begin
      cur_width = 11'd1;
      cur_height = 13'd1;
      cur_coef_a = '0;
      cur_coef_b = '0;
      cur_coef_c = '0;
      cur_lo = 16'sh8000;
      cur_hi = 16'sh7fff;
      at_row = 0;
      at_col = 0;
      win_left = '0;
      win_mid = '0;
      conv_pixels_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  cur_width = cfg_data[10:0];
          REG_FRAME_HEIGHT: cur_height = cfg_data[12:0];
          REG_COEF_A:       cur_coef_a = cfg_data;
          REG_COEF_B:       cur_coef_b = cfg_data;
          REG_COEF_C:       cur_coef_c = cfg_data[31:0];
          REG_CLAMP_LOW:    cur_lo = cfg_data[15:0];
          REG_CLAMP_HIGH:   cur_hi = cfg_data[15:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        track_sample(s_axis_tdata);
        samples_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (conv_pixels_due.size() == 0) begin
          report_mismatch("output with nothing pending", $signed(m_axis_tdata), 0);
        end else begin
          want = conv_pixels_due.pop_front();
          if (m_axis_tdata !== want.value)
            report_mismatch("value", $signed(m_axis_tdata), want.value);
          if (m_axis_tlast !== want.run_last)
            report_mismatch("run_last", m_axis_tlast, want.run_last);
          if (m_axis_tuser[0] !== want.row_end)
            report_mismatch("row_end", m_axis_tuser[0], want.row_end);
          if (m_axis_tuser[1] !== want.frame_end)
            report_mismatch("frame_end", m_axis_tuser[1], want.frame_end);
          if (want.frame_end) frames_closed++;
          pixels_checked++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("depthwise_conv3x3_pad1_clamp_tb: FAIL");
      $finish;
    end
  end

  function automatic logic [15:0] rand_tap();
    logic [15:0] x;
    x = 16'($urandom);
    case ($urandom_range(0, 4))
      0: return x;
      1: return 16'h4000;
      2: return 16'hc000;
      3: return {{5{x[10]}}, x[10:0]};
      default: return 16'h0000;
    endcase
  endfunction

  function automatic sample_t rand_sample();
    logic [15:0] x;
    x = 16'($urandom);
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2, 3: return {{6{x[9]}}, x[9:0]};
      default: return x;
    endcase
  endfunction

  // one config transaction; valid stays up for a following write
  task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_all(int unsigned wreg, int unsigned hreg, logic [63:0] ca,
                           logic [63:0] cb, logic [31:0] cc, sample_t lo, sample_t hi);
    write_reg(REG_FRAME_WIDTH, 64'(wreg));
    write_reg(REG_FRAME_HEIGHT, 64'(hreg));
    write_reg(REG_COEF_A, ca);
    write_reg(REG_COEF_B, cb);
    write_reg(REG_COEF_C, {32'h0, cc});
    write_reg(REG_CLAMP_LOW, {48'h0, lo});
    write_reg(REG_CLAMP_HIGH, {48'h0, hi});
    cfg_valid <= 1'b0;
    last_coef_a = ca;
    last_coef_b = cb;
    last_coef_c = cc;
    last_lo = lo;
    last_hi = hi;
  endtask

  task automatic write_random_cfg(int unsigned wreg, int unsigned hreg);
    sample_t lo, hi, t;
    case ($urandom_range(0, 9))
      // arbitrary bounds, inverted ones included
      0: begin
        lo = sample_t'($urandom);
        hi = sample_t'($urandom);
      end
      1, 2, 3: begin
        lo = sample_t'($urandom);
        hi = sample_t'($urandom);
        if (lo > hi) begin
          t = lo;
          lo = hi;
          hi = t;
        end
      end
      default: begin
        lo = 16'sh8000;
        hi = 16'sh7fff;
      end
    endcase
    write_all(wreg, hreg, {rand_tap(), rand_tap(), rand_tap(), rand_tap()},
              {rand_tap(), rand_tap(), rand_tap(), rand_tap()},
              {rand_tap(), rand_tap()}, lo, hi);
  endtask

  task automatic push_sample(sample_t s);
    samples_to_send.push_back(s);
    samples_queued++;
  endtask

  // all results in, then let the pipeline settle before touching registers
  task automatic wait_idle();
    while (samples_to_send.size() != 0 || s_axis_tvalid || conv_pixels_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // a whole plane plus its padding row of don't-care samples
  task automatic send_plane(int unsigned wreg, int unsigned hreg);
    int unsigned w, h, i;
    w = (wreg == 0) ? 1 : (wreg > MAX_W) ? MAX_W : wreg;
    h = (hreg == 0) ? 1 : (hreg > MAX_H) ? MAX_H : hreg;
    for (i = 0; i < w * h; i++) push_sample(rand_sample());
    for (i = 0; i < w; i++) push_sample(sample_t'($urandom));
    wait_idle();
  endtask

  initial begin : stimulus
    int unsigned wr, hr, first_random, i;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers at their reset values: one pixel plane
    push_sample(16'sh7fff);
    push_sample(16'sh1234);
    wait_idle();

    // all taps at one, bias one: saturation at both ends
    write_all(3, 2, {16'h4000, 16'h4000, 16'h4000, 16'h0100}, {4{16'h4000}},
              {2{16'h4000}}, 16'sh8000, 16'sh7fff);
    for (i = 0; i < 3; i++) push_sample(16'sh7fff);
    for (i = 0; i < 3; i++) push_sample(16'sh8000);
    for (i = 0; i < 3; i++) push_sample(sample_t'($urandom));
    wait_idle();

    // zero width and height taken as one; half-step rounds up
    write_all(0, 0, 64'h0, {16'h0, 16'h0, 16'h2000, 16'h0}, 32'h0, 16'sh8000, 16'sh7fff);
    push_sample(16'sh0001);
    push_sample(sample_t'($urandom));
    wait_idle();

    // inverted bounds give the upper bound
    write_all(0, 0, 64'h0, {16'h0, 16'h0, 16'h2000, 16'h0}, 32'h0, 16'sd100, -16'sd100);
    push_sample(16'sh0001);
    push_sample(sample_t'($urandom));
    wait_idle();

    // shrink width and height in mid-plane: position folds onto the new edges
    write_random_cfg(3, 5);
    for (i = 0; i < 8; i++) push_sample(rand_sample());
    wait_idle();
    write_all(2, 1, last_coef_a, last_coef_b, last_coef_c, last_lo, last_hi);
    push_sample(sample_t'($urandom));
    wait_idle();
    send_plane(2, 1);

    // random planes, idling pattern changes by thirds
    first_random = samples_queued;
    while (samples_queued - first_random < RANDOM_SAMPLES) begin
      if (samples_queued - first_random >= 2 * RANDOM_SAMPLES / 3) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end else if (samples_queued - first_random >= RANDOM_SAMPLES / 3) begin
        send_idle_pct <= 77;
        recv_idle_pct <= 29;
      end
      case ($urandom_range(0, 9))
        0: wr = 0;
        1: wr = $urandom_range(13, 64);
        default: wr = $urandom_range(1, 12);
      endcase
      hr = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      write_random_cfg(wr, hr);
      send_plane(wr, hr);
    end

    // register values above the size limits, each plane closed by a mid-plane shrink
    write_random_cfg(2047, 1);
    for (i = 0; i < 20; i++) push_sample(rand_sample());
    wait_idle();
    write_all(4, 1, last_coef_a, last_coef_b, last_coef_c, last_lo, last_hi);
    for (i = 0; i < 5; i++) push_sample(rand_sample());
    wait_idle();
    write_random_cfg(2, 8191);
    for (i = 0; i < 12; i++) push_sample(rand_sample());
    wait_idle();
    write_all(2, 1, last_coef_a, last_coef_b, last_coef_c, last_lo, last_hi);
    for (i = 0; i < 2; i++) push_sample(sample_t'($urandom));
    wait_idle();

    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (conv_pixels_due.size() != 0)
      report_mismatch("results never arrived", 0, conv_pixels_due.size());
    $display("covered %0d samples and %0d closed planes, small random sizes plus oversized",
             samples_taken, frames_closed);
    $display("checked %0d output pixels, %0d mismatches", pixels_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("depthwise_conv3x3_pad1_clamp_tb: PASS");
    end else begin
      $display("depthwise_conv3x3_pad1_clamp_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: depthwise_conv3x3_pad1_clamp.f
hw/rtl/dwc3_pkg.sv
hw/rtl/depthwise_conv3x3_pad1_clamp.sv
bench/depthwise_conv3x3_pad1_clamp_tb.sv
